// ===== design/mailbox_queue_bank_unit_macros.svh =====
// Assertion macros for the mailbox queue bank.
// Used by mailbox_queue_bank_unit.sv; expects signals named clock and reset in scope.
`ifndef MAILBOX_QUEUE_BANK_UNIT_MACROS_SVH
`define MAILBOX_QUEUE_BANK_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define MQB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mailbox bank check failed");
// Next-cycle implication.
`define MQB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mailbox bank sequencing check failed");
`else
`define MQB_ASSERT_IMP(label, ante, cons)
`define MQB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/mqb_pkg.sv =====
// Shared types and constants for the mailbox queue bank.
// No dependencies; imported by mailbox_queue_bank_unit.
package mqb_pkg;

   localparam int ACTION_W    = 2;
   localparam int BOX_INDEX_W = 10;
   localparam int MSG_W       = 32;
   localparam int STATUS_W    = 2;

   // Shift of the fixed-point reciprocal used to wrap the mailbox index.
   localparam int RECIP_SHIFT = 20;

   // Action codes; the fourth code is unused and has no effect.
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEND    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RECEIVE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EXISTS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

endpackage

// ===== design/mqb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the mailbox pointer store and the message store.
module mqb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mailbox_queue_bank_unit.sv =====
// Mailbox queue bank: many small circular message queues kept in two RAMs.
// Depends on mqb_pkg, mqb_ram and mailbox_queue_bank_unit_macros.svh.
//
//   Channel    Ports                                          Handshake
//   request    req_action, req_box_index, req_message         start high, busy low
//   response   rsp_status, rsp_data                           rsp_strobe, one cycle
//
// Each request reads a mailbox's pointer word and writes it back only when it changes.
// After acceptance the index is wrapped into range (a reciprocal multiply into quot_ff,
// then a correction into box_ff), the pointer word is read and evaluated, and the strobe
// rises from the evaluation state; a successful receive reads the message RAM once more
// and answers from the data state instead. A new request can be accepted in the cycle in
// which the response is shown. After reset the pointer RAM is swept to zero, one mailbox
// per cycle, and busy stays high until the sweep is done. The receiver cannot stall.
`include "mailbox_queue_bank_unit_macros.svh"

module mailbox_queue_bank_unit
   import mqb_pkg::*;
#(
   parameter int NUM_BOXES   = 1024,
   parameter int QUEUE_DEPTH = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [BOX_INDEX_W-1:0]     req_box_index,
   input  logic signed [MSG_W-1:0]    req_message,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [MSG_W-1:0]    rsp_data
);

   // Widths derived from the bank geometry.
   localparam int BOX_W  = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
   localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int META_W = 1 + HEAD_W + CNT_W;
   localparam int SLOTS  = NUM_BOXES * QUEUE_DEPTH;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // The index is wrapped modulo NUM_BOXES with a truncated reciprocal. For any 10-bit
   // index the estimated quotient is at most one short, so one correction step suffices.
   localparam int RECIP  = (2 ** RECIP_SHIFT) / NUM_BOXES;
   localparam int PROD_W = BOX_INDEX_W + RECIP_SHIFT + 1;
   localparam int REM_W  = BOX_INDEX_W + 18;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_ADDR,
      S_META,
      S_EVAL,
      S_DATA
   } state_type;

   state_type                 state_ff;
   logic [ACTION_W-1:0]       act_ff;
   logic [BOX_INDEX_W-1:0]    idx_ff;
   logic [MSG_W-1:0]          msg_ff;
   logic [BOX_INDEX_W-1:0]    quot_ff;
   logic [BOX_INDEX_W-1:0]    quot_in;
   logic [BOX_W-1:0]          box_ff;
   logic [BOX_W-1:0]          box_in;
   logic [SLOT_W-1:0]         base_ff;
   logic [SLOT_W-1:0]         base_in;
   logic [BOX_W-1:0]          clr_ff;
   logic                      rsp_strobe_ff;
   status_type                rsp_status_ff;
   logic [MSG_W-1:0]          rsp_data_ff;

   logic [PROD_W-1:0]         recip_prod;
   logic [REM_W-1:0]          rem_raw;
   logic [REM_W-1:0]          rem_fix;

   // Pointer RAM: valid mark, head slot and fill count of every mailbox.
   logic                      meta_wr_en;
   logic [BOX_W-1:0]          meta_wr_addr;
   logic [META_W-1:0]         meta_wr_data;
   logic                      meta_rd_en;
   logic [META_W-1:0]         meta_rd_data;

   // Message RAM: QUEUE_DEPTH slots per mailbox.
   logic                      msg_wr_en;
   logic                      msg_rd_en;
   logic [SLOT_W-1:0]         msg_addr;
   logic [MSG_W-1:0]          msg_rd_data;

   // Fields of the pointer word read for the current request.
   logic                      cur_valid;
   logic [HEAD_W-1:0]         cur_head;
   logic [CNT_W-1:0]          cur_cnt;
   logic [SUM_W-1:0]          tail_sum;
   logic [HEAD_W-1:0]         tail_slot;
   logic [HEAD_W-1:0]         head_next;

   // Outcome of the evaluation cycle.
   status_type                eval_status;
   logic                      eval_meta_wr;
   logic [META_W-1:0]         eval_meta;
   logic                      eval_msg_wr;
   logic                      eval_msg_rd;

   // ---------------------------------------------------------------------------------
   // Index wrap and slot base.
   // ---------------------------------------------------------------------------------
   always_comb begin
      recip_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
      quot_in    = BOX_INDEX_W'(recip_prod >> RECIP_SHIFT);
   end

   always_comb begin
      rem_raw = REM_W'(idx_ff) - REM_W'(quot_ff) * REM_W'(NUM_BOXES);
      if (rem_raw >= REM_W'(NUM_BOXES)) begin
         rem_fix = rem_raw - REM_W'(NUM_BOXES);
      end else begin
         rem_fix = rem_raw;
      end
      box_in = BOX_W'(rem_fix);
   end

   // The base of the mailbox's slots is formed while its pointer word is being read.
   assign base_in = SLOT_W'(box_ff) * SLOT_W'(QUEUE_DEPTH);

   // ---------------------------------------------------------------------------------
   // Evaluation of one request against its pointer word.
   // ---------------------------------------------------------------------------------
   assign cur_valid = meta_rd_data[META_W-1];
   assign cur_head  = meta_rd_data[HEAD_W+CNT_W-1:CNT_W];
   assign cur_cnt   = meta_rd_data[CNT_W-1:0];

   always_comb begin
      tail_sum = SUM_W'(cur_head) + SUM_W'(cur_cnt);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail_slot = HEAD_W'(tail_sum);
      if (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = cur_head + HEAD_W'(1);
      end
   end

   always_comb begin
      eval_status  = ST_OK;
      eval_meta_wr = 1'b0;
      eval_meta    = meta_rd_data;
      eval_msg_wr  = 1'b0;
      eval_msg_rd  = 1'b0;
      unique case (act_ff)
         ACT_CREATE: begin
            if (cur_valid) begin
               eval_status = ST_EXISTS;
            end else begin
               eval_meta_wr = 1'b1;
               eval_meta    = {1'b1, cur_head, cur_cnt};
            end
         end
         ACT_SEND: begin
            if (cur_cnt >= CNT_W'(QUEUE_DEPTH)) begin
               eval_status = ST_FULL;
            end else begin
               eval_meta_wr = 1'b1;
               eval_meta    = {cur_valid, cur_head, cur_cnt + CNT_W'(1)};
               eval_msg_wr  = 1'b1;
            end
         end
         ACT_RECEIVE: begin
            if (cur_cnt == '0) begin
               eval_status = ST_EMPTY;
            end else begin
               eval_meta_wr = 1'b1;
               eval_meta    = {cur_valid, head_next, cur_cnt - CNT_W'(1)};
               eval_msg_rd  = 1'b1;
            end
         end
         default: begin
            // Unused action code: answered with ok and no change.
            eval_status = ST_OK;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // RAM ports. The clearing sweep owns the pointer write port after reset.
   // ---------------------------------------------------------------------------------
   always_comb begin
      if (state_ff == S_CLEAR) begin
         meta_wr_en   = 1'b1;
         meta_wr_addr = clr_ff;
         meta_wr_data = '0;
      end else begin
         meta_wr_en   = (state_ff == S_EVAL) && eval_meta_wr;
         meta_wr_addr = box_ff;
         meta_wr_data = eval_meta;
      end
   end

   assign meta_rd_en = (state_ff == S_META);
   assign msg_wr_en  = (state_ff == S_EVAL) && eval_msg_wr;
   assign msg_rd_en  = (state_ff == S_EVAL) && eval_msg_rd;
   assign msg_addr   = base_ff + SLOT_W'(eval_msg_wr ? tail_slot : cur_head);

   mqb_ram #(
      .WIDTH (META_W),
      .DEPTH (NUM_BOXES)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (box_ff),
      .rd_data (meta_rd_data)
   );

   mqb_ram #(
      .WIDTH (MSG_W),
      .DEPTH (SLOTS)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_wr_en),
      .wr_addr (msg_addr),
      .wr_data (msg_ff),
      .rd_en   (msg_rd_en),
      .rd_addr (msg_addr),
      .rd_data (msg_rd_data)
   );

   // ---------------------------------------------------------------------------------
   // Sequencer and response register.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + BOX_W'(1);
               if (clr_ff == BOX_W'(NUM_BOXES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  act_ff   <= req_action;
                  idx_ff   <= req_box_index;
                  msg_ff   <= req_message;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               quot_ff  <= quot_in;
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               box_ff   <= box_in;
               state_ff <= S_META;
            end
            S_META: begin
               base_ff  <= base_in;
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (eval_msg_rd) begin
                  state_ff <= S_DATA;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= eval_status;
                  rsp_data_ff   <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            S_DATA: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_data_ff   <= msg_rd_data;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------
   // A response always closes its request, so the block is ready while it is shown.
   `MQB_ASSERT_IMP(a_rsp_closes_request, rsp_strobe_ff, state_ff == S_IDLE)
   // An accepted request keeps the block busy in the following cycle.
   `MQB_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !rsp_strobe_ff)
   // Only a successful receive carries message data.
   `MQB_ASSERT_IMP(a_data_only_on_ok, rsp_strobe_ff && (rsp_status_ff != ST_OK),
                   rsp_data_ff == '0)
   // A stored fill count never exceeds the queue depth.
   `MQB_ASSERT_IMP(a_count_in_range, state_ff == S_EVAL,
                   cur_cnt <= CNT_W'(QUEUE_DEPTH))
   // The data state, which holds the message read, is followed by its response in the next cycle.
   `MQB_ASSERT_NEXT(a_read_answers, state_ff == S_DATA, rsp_strobe_ff)

endmodule
